// ===== rtl/core/dfd_pkg.sv =====
// dfd_pkg: shared types, codes and helpers for the detector frame deframer
// used by dfd_parser and detector_frame_deframer_top; no dependencies

package dfd_pkg;

    // framing bytes
    localparam logic [7:0] SYNC1_BYTE = 8'hEB;
    localparam logic [7:0] SYNC2_BYTE = 8'h90;
    localparam logic [7:0] TAG1_BYTE  = 8'hE2;
    localparam logic [7:0] TAG2_BYTE  = 8'h25;

    // frame layout
    localparam int unsigned DEF_NUM_CHANNELS = 192;
    localparam logic [15:0] HEADER_LEN       = 16'd6;
    localparam logic [3:0]  TRAILER_BYTES    = 4'd4;
    localparam logic [3:0]  GAP_BYTES        = 4'd6;
    localparam logic [3:0]  TIME_BYTES       = 4'd8;

    // floor(x/3) == (x * RECIP3) >> RECIP3_SHIFT for every 16-bit x
    localparam logic [16:0] RECIP3       = 17'd43691;
    localparam int unsigned RECIP3_SHIFT = 17;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_MODE    = 2'd0;
    localparam logic [1:0] CFG_TIME_TAG_MODE = 2'd1;
    localparam logic [1:0] CFG_PAD_SKIP      = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_TRIG,
        PH_MODE,
        PH_LENHI,
        PH_LENLO,
        PH_TRIPLE,
        PH_PAD,
        PH_TRAILER,
        PH_TAG1,
        PH_TAG2,
        PH_GAP,
        PH_TIME
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_TRIG_ERR,
        KIND_EVENT
    } t_kind;

    typedef struct packed {
        logic [7:0] frame_mode;
        logic       time_tag_mode;
        logic       pad_skip;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  channel;
        logic [15:0] adc;
        logic [7:0]  trigger;
        logic [8:0]  expected_trigger;
        logic [63:0] timestamp;
        logic        time_valid;
        logic [31:0] frame_count;
    } t_result;

    // nonzero remainder mod 3, from base-4 digit sums (4 is 1 mod 3)
    function automatic logic mod3_nz(input logic [15:0] x);
        logic [4:0] sum;
        logic [2:0] fold;
        sum = '0;
        for (int k = 0; k < 8; k++) begin
            sum = sum + 5'(x[2*k +: 2]);
        end
        fold = 3'(sum[1:0]) + 3'(sum[3:2]) + 3'(sum[4]);
        return !(fold == 3'd0 || fold == 3'd3 || fold == 3'd6);
    endfunction

endpackage

// ===== rtl/core/detector_frame_deframer_top.sv =====
// detector_frame_deframer_top: configuration registers, input handshake and result register
// depends on dfd_pkg and dfd_parser

// Takes one raw stream byte per clock cycle, every cycle, for as long as the
// result register is empty or being drained in that same cycle. A byte is
// parsed in the cycle it transfers and its result, if any, is presented on
// the output from the next cycle on, and the sustained rate is one byte per
// cycle; the single result register between the parse logic and the output
// is what sets both the output timing and the rate. Configuration writes take
// effect on the next byte that reaches the point where the register is used.
module detector_frame_deframer_top #(
    parameter int unsigned NUM_CHANNELS = dfd_pkg::DEF_NUM_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_raw_byte,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_channel,
    output logic [15:0] o_adc,
    output logic [7:0]  o_trigger,
    output logic [8:0]  o_expected_trigger,
    output logic [63:0] o_timestamp,
    output logic        o_time_valid,
    output logic [31:0] o_frame_count
);

    dfd_pkg::t_cfg    r_cfg;
    dfd_pkg::t_result res;
    dfd_pkg::t_result r_out;
    logic             res_valid;
    logic             r_out_valid;
    logic             step;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_mode    <= '0;
            r_cfg.time_tag_mode <= 1'b1;
            r_cfg.pad_skip      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dfd_pkg::CFG_FRAME_MODE:    r_cfg.frame_mode    <= i_cfg_data;
                dfd_pkg::CFG_TIME_TAG_MODE: r_cfg.time_tag_mode <= i_cfg_data[0];
                dfd_pkg::CFG_PAD_SKIP:      r_cfg.pad_skip      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input transfer whenever the result register has room
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    dfd_parser #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (i_raw_byte),
        .i_cfg      (r_cfg),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_out.kind;
    assign o_channel          = r_out.channel;
    assign o_adc              = r_out.adc;
    assign o_trigger          = r_out.trigger;
    assign o_expected_trigger = r_out.expected_trigger;
    assign o_timestamp        = r_out.timestamp;
    assign o_time_valid       = r_out.time_valid;
    assign o_frame_count      = r_out.frame_count;

endmodule

// ===== rtl/core/dfd_parser.sv =====
// dfd_parser: frame parsing state and per-byte next-state and result logic
// depends on dfd_pkg

module dfd_parser #(
    parameter int unsigned NUM_CHANNELS = dfd_pkg::DEF_NUM_CHANNELS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  dfd_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output dfd_pkg::t_result o_res
);

    dfd_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [14:0] r_triples_left, n_triples_left;
    logic [1:0]  r_trip_pos, n_trip_pos;
    logic [7:0]  r_held_ch, n_held_ch;
    logic [7:0]  r_held_adc_hi, n_held_adc_hi;
    logic [3:0]  r_skip, n_skip;
    logic [7:0]  r_last_trig, n_last_trig;
    logic [31:0] r_frames, n_frames;
    logic [63:0] r_time, n_time;
    logic        r_time_seen, n_time_seen;

    // length arithmetic for the low length byte
    logic [15:0] len_new;
    logic [15:0] len_m6;
    logic [32:0] quot_prod;
    logic [14:0] triples_new;
    logic [8:0]  trig_plus1;
    logic [14:0] triples_dec;

    assign len_new     = {r_len[15:8], i_byte};
    assign len_m6      = len_new - dfd_pkg::HEADER_LEN;
    assign quot_prod   = 33'(len_m6) * 33'(dfd_pkg::RECIP3);
    assign triples_new = (len_new >= dfd_pkg::HEADER_LEN) ? quot_prod[31:17] : '0;
    assign trig_plus1  = 9'(r_last_trig) + 9'd1;
    assign triples_dec = r_triples_left - 15'd1;

    // next state and result
    always_comb begin
        n_phase        = r_phase;
        n_len          = r_len;
        n_triples_left = r_triples_left;
        n_trip_pos     = r_trip_pos;
        n_held_ch      = r_held_ch;
        n_held_adc_hi  = r_held_adc_hi;
        n_skip         = r_skip;
        n_last_trig    = r_last_trig;
        n_frames       = r_frames;
        n_time         = r_time;
        n_time_seen    = r_time_seen;
        o_res_valid    = 1'b0;
        o_res          = '0;

        case (r_phase)
            dfd_pkg::PH_HUNT: begin
                if (i_byte == dfd_pkg::SYNC1_BYTE) begin
                    n_phase = dfd_pkg::PH_SYNC2;
                end
            end
            dfd_pkg::PH_SYNC2: begin
                n_phase = (i_byte == dfd_pkg::SYNC2_BYTE) ? dfd_pkg::PH_TRIG
                                                          : dfd_pkg::PH_HUNT;
            end
            dfd_pkg::PH_TRIG: begin
                n_phase     = dfd_pkg::PH_MODE;
                n_last_trig = i_byte;
                // sequence check only once a frame has completed
                if ((r_frames != '0) && (i_byte != '0) && (trig_plus1 != 9'(i_byte))) begin
                    o_res_valid            = 1'b1;
                    o_res.kind             = dfd_pkg::KIND_TRIG_ERR;
                    o_res.trigger          = i_byte;
                    o_res.expected_trigger = trig_plus1;
                end
            end
            dfd_pkg::PH_MODE: begin
                n_phase = (i_byte == i_cfg.frame_mode) ? dfd_pkg::PH_LENHI
                                                       : dfd_pkg::PH_HUNT;
            end
            dfd_pkg::PH_LENHI: begin
                n_len   = {i_byte, 8'h00};
                n_phase = dfd_pkg::PH_LENLO;
            end
            dfd_pkg::PH_LENLO: begin
                n_len          = len_new;
                n_triples_left = triples_new;
                n_trip_pos     = 2'd0;
                if (triples_new != '0) begin
                    n_phase = dfd_pkg::PH_TRIPLE;
                end else if (i_cfg.pad_skip && dfd_pkg::mod3_nz(len_new)) begin
                    n_phase = dfd_pkg::PH_PAD;
                end else begin
                    n_phase = dfd_pkg::PH_TRAILER;
                    n_skip  = dfd_pkg::TRAILER_BYTES;
                end
            end
            dfd_pkg::PH_TRIPLE: begin
                if (r_trip_pos == 2'd0) begin
                    n_held_ch  = i_byte;
                    n_trip_pos = 2'd1;
                end else if (r_trip_pos == 2'd1) begin
                    n_held_adc_hi = i_byte;
                    n_trip_pos    = 2'd2;
                end else begin
                    n_trip_pos     = 2'd0;
                    n_triples_left = triples_dec;
                    if (triples_dec == '0) begin
                        if (i_cfg.pad_skip && dfd_pkg::mod3_nz(r_len)) begin
                            n_phase = dfd_pkg::PH_PAD;
                        end else begin
                            n_phase = dfd_pkg::PH_TRAILER;
                            n_skip  = dfd_pkg::TRAILER_BYTES;
                        end
                    end
                    // out-of-range channels still consume their adc bytes
                    if (9'(r_held_ch) < 9'(NUM_CHANNELS)) begin
                        o_res_valid   = 1'b1;
                        o_res.kind    = dfd_pkg::KIND_SAMPLE;
                        o_res.channel = r_held_ch;
                        o_res.adc     = {r_held_adc_hi, i_byte};
                    end
                end
            end
            dfd_pkg::PH_PAD: begin
                n_phase = dfd_pkg::PH_TRAILER;
                n_skip  = dfd_pkg::TRAILER_BYTES;
            end
            dfd_pkg::PH_TRAILER: begin
                n_skip = r_skip - 4'd1;
                if (n_skip == '0) begin
                    n_frames = r_frames + 32'd1;
                    n_phase  = i_cfg.time_tag_mode ? dfd_pkg::PH_TAG1 : dfd_pkg::PH_HUNT;
                end
            end
            dfd_pkg::PH_TAG1: begin
                n_phase = (i_byte == dfd_pkg::TAG1_BYTE) ? dfd_pkg::PH_TAG2
                                                         : dfd_pkg::PH_HUNT;
            end
            dfd_pkg::PH_TAG2: begin
                if (i_byte == dfd_pkg::TAG2_BYTE) begin
                    n_phase = dfd_pkg::PH_GAP;
                    n_skip  = dfd_pkg::GAP_BYTES;
                end else begin
                    // broken tag: commit with the previous timestamp
                    n_phase           = dfd_pkg::PH_HUNT;
                    o_res_valid       = 1'b1;
                    o_res.kind        = dfd_pkg::KIND_EVENT;
                    o_res.timestamp   = r_time;
                    o_res.time_valid  = r_time_seen;
                    o_res.frame_count = r_frames;
                end
            end
            dfd_pkg::PH_GAP: begin
                n_skip = r_skip - 4'd1;
                if (n_skip == '0) begin
                    n_phase = dfd_pkg::PH_TIME;
                    n_skip  = dfd_pkg::TIME_BYTES;
                end
            end
            dfd_pkg::PH_TIME: begin
                n_time = {r_time[55:0], i_byte};
                n_skip = r_skip - 4'd1;
                if (n_skip == '0) begin
                    n_time_seen       = 1'b1;
                    n_phase           = dfd_pkg::PH_HUNT;
                    o_res_valid       = 1'b1;
                    o_res.kind        = dfd_pkg::KIND_EVENT;
                    o_res.timestamp   = n_time;
                    o_res.time_valid  = 1'b1;
                    o_res.frame_count = r_frames;
                end
            end
            default: begin
                n_phase = dfd_pkg::PH_HUNT;
            end
        endcase
    end

    // parse state, advanced once per transferred byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= dfd_pkg::PH_HUNT;
            r_len          <= '0;
            r_triples_left <= '0;
            r_trip_pos     <= '0;
            r_held_ch      <= '0;
            r_held_adc_hi  <= '0;
            r_skip         <= '0;
            r_last_trig    <= '0;
            r_frames       <= '0;
            r_time         <= '0;
            r_time_seen    <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_len          <= n_len;
            r_triples_left <= n_triples_left;
            r_trip_pos     <= n_trip_pos;
            r_held_ch      <= n_held_ch;
            r_held_adc_hi  <= n_held_adc_hi;
            r_skip         <= n_skip;
            r_last_trig    <= n_last_trig;
            r_frames       <= n_frames;
            r_time         <= n_time;
            r_time_seen    <= n_time_seen;
        end
    end

    // checks
    a_reset_hunts: assert property (@(posedge i_clk)
        !i_rst_n |=> r_phase == dfd_pkg::PH_HUNT)
        else $error("parser not hunting after reset");

    a_triples_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dfd_pkg::PH_TRIPLE |-> r_triples_left != '0)
        else $error("triple phase with no triples left");

    a_sample_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == dfd_pkg::KIND_SAMPLE
            |-> 9'(o_res.channel) < 9'(NUM_CHANNELS))
        else $error("sample emitted for out-of-range channel");

    a_event_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == dfd_pkg::KIND_EVENT
            |-> (r_phase == dfd_pkg::PH_TAG2 || r_phase == dfd_pkg::PH_TIME))
        else $error("event committed outside the time tag");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_frames))
        else $error("parse state moved without a transfer");

endmodule
